FILE: sv/acts_pkg.sv
// acts_pkg: shared types and constants of the ANSI cursor text screen unit
// holds screen geometry, character codes, parser phases and item structs
// no dependencies
package acts_pkg;

	// screen geometry
	localparam int ROWS   = 24;
	localparam int COLS   = 80;
	localparam int CELLS  = ROWS * COLS;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int MOVE_W = 9;   // room for cursor plus a full count

	// character codes
	localparam logic [7:0] CH_ESC      = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UP       = 8'h41;
	localparam logic [7:0] CH_DOWN     = 8'h42;
	localparam logic [7:0] CH_RIGHT    = 8'h43;
	localparam logic [7:0] CH_LEFT     = 8'h44;

	// item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// register indexes
	localparam logic REG_OBEY = 1'b0;

	// parser phase, one-hot
	typedef enum logic [2:0] {
		PH_TEXT = 3'b001,
		PH_ESC  = 3'b010,
		PH_CSI  = 3'b100
	} phase_t;

	typedef struct packed {
		logic             kind;
		logic [7:0]       data_byte;
		logic [ROW_W-1:0] read_row;
		logic [COL_W-1:0] read_col;
	} req_t;

	typedef struct packed {
		logic [7:0]       cell_char;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic             cell_written;
	} rsp_t;

	// item waiting on the cell read
	typedef struct packed {
		logic             is_read;
		logic             in_range;
		logic [ROW_W-1:0] cursor_row;
		logic [COL_W-1:0] cursor_col;
		logic             cell_written;
	} s1_t;

endpackage

FILE: sv/ansi_cursor_text_screen_unit.sv
// ansi_cursor_text_screen_unit: text terminal engine, 24 x 80 screen in a RAM
// depends on acts_pkg and acts_ram
//
// Usage: the req channel takes one item per cycle while req_stall is low,
// either a terminal byte or a read of one screen cell. Bytes drive an ESC
// '[' count A/B/C/D cursor parser and are otherwise written at the cursor,
// which then advances and wraps with no scrolling. LF and CR are obeyed or
// stored as characters as register 0 (obey_line_controls, reset 1) selects;
// write it over APB only while the block is idle.
// Every item gives exactly one rsp item: the cell character (zero for
// bytes), the cursor after the item and a written flag.
// An accepted item passes the read stage, where the screen RAM is read, and
// then the output register before rsp_valid. Throughput is one item per
// cycle while req_stall is low; cursor and parser live in registers and each
// byte makes at most one RAM write, so nothing loops back across cycles.
// After reset a clearing pass writes spaces to all 1920 cells, one per
// cycle; req_stall stays high until the pass is done.
// When rsp_stall is high the output holds, one item waits in the read
// stage, and req_stall rises once both are full.
module ansi_cursor_text_screen_unit
	import acts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// architectural state
	logic             obey_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [COL_W-1:0] cur_col_q;
	phase_t           phase_q;
	logic [7:0]       count_q;
	logic             seen_q;

	// clearing pass
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// pipeline
	logic  s1_valid_s1;
	s1_t   s1_s1;
	logic  out_valid_q;
	rsp_t  out_q;

	logic             accept;
	logic             s1_go;
	logic             out_free;
	logic             is_byte;

	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;
	phase_t           nxt_phase;
	logic [7:0]       nxt_count;
	logic             nxt_seen;
	logic             nxt_written;

	logic [11:0]       acc;
	logic [7:0]        step;
	logic [MOVE_W-1:0] row_w;
	logic [MOVE_W-1:0] col_w;
	logic [MOVE_W-1:0] step_w;
	logic [MOVE_W-1:0] row_sum;
	logic [MOVE_W-1:0] col_sum;

	logic              rd_in_range;
	logic [ADDR_W:0]   rd_addr_full;
	logic [ADDR_W:0]   wr_addr_full;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	// handshake
	assign out_free  = !out_valid_q || !rsp_stall;
	assign s1_go     = !s1_valid_s1 || out_free;
	assign req_stall = clr_busy_q || !s1_go;
	assign accept    = req_valid && !req_stall;
	assign is_byte   = (req.kind == KIND_BYTE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_OBEY) ? {31'd0, obey_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obey_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_OBEY) begin
			obey_q <= pwdata[0];
		end
	end

	// byte parser and cursor update
	assign row_w   = MOVE_W'(cur_row_q);
	assign col_w   = MOVE_W'(cur_col_q);
	assign step    = seen_q ? count_q : 8'd1;
	assign step_w  = MOVE_W'(step);
	assign row_sum = row_w + step_w;
	assign col_sum = col_w + step_w;
	assign acc     = {1'b0, count_q, 3'b000} + {3'b000, count_q, 1'b0}
		+ {8'd0, req.data_byte[3:0] - CH_ZERO[3:0]};

	always_comb begin
		nxt_row     = cur_row_q;
		nxt_col     = cur_col_q;
		nxt_phase   = phase_q;
		nxt_count   = count_q;
		nxt_seen    = seen_q;
		nxt_written = 1'b0;
		case (phase_q)
			PH_ESC: begin
				if (req.data_byte == CH_LBRACKET) begin
					nxt_phase = PH_CSI;
					nxt_count = 8'd0;
					nxt_seen  = 1'b0;
				end else begin
					nxt_phase = PH_TEXT;
				end
			end
			PH_CSI: begin
				if (req.data_byte >= CH_ZERO && req.data_byte <= CH_NINE) begin
					// count = count * 10 + digit, saturating
					nxt_count = (acc > 12'd255) ? 8'd255 : acc[7:0];
					nxt_seen  = 1'b1;
				end else begin
					case (req.data_byte)
						CH_UP: begin
							nxt_row = (step_w >= row_w) ? '0 : ROW_W'(row_w - step_w);
						end
						CH_DOWN: begin
							nxt_row = (row_sum >= MOVE_W'(ROWS)) ? ROW_W'(ROWS - 1)
								: ROW_W'(row_sum);
						end
						CH_RIGHT: begin
							nxt_col = (col_sum >= MOVE_W'(COLS)) ? COL_W'(COLS - 1)
								: COL_W'(col_sum);
						end
						CH_LEFT: begin
							nxt_col = (step_w >= col_w) ? '0 : COL_W'(col_w - step_w);
						end
						default: begin
						end
					endcase
					nxt_phase = PH_TEXT;
					nxt_count = 8'd0;
					nxt_seen  = 1'b0;
				end
			end
			default: begin
				nxt_phase = PH_TEXT;
				if (req.data_byte == CH_ESC) begin
					nxt_phase = PH_ESC;
				end else if (obey_q && req.data_byte == CH_LF) begin
					if (cur_row_q < ROW_W'(ROWS - 1)) begin
						nxt_row = cur_row_q + ROW_W'(1);
					end
					nxt_col = '0;
				end else if (obey_q && req.data_byte == CH_CR) begin
					nxt_col = '0;
				end else begin
					// print and advance, wrapping without scroll
					nxt_written = 1'b1;
					if (cur_col_q >= COL_W'(COLS - 1)) begin
						nxt_col = '0;
						if (cur_row_q < ROW_W'(ROWS - 1)) begin
							nxt_row = cur_row_q + ROW_W'(1);
						end
					end else begin
						nxt_col = cur_col_q + COL_W'(1);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
			phase_q   <= PH_TEXT;
			count_q   <= 8'd0;
			seen_q    <= 1'b0;
		end else if (accept && is_byte) begin
			cur_row_q <= nxt_row;
			cur_col_q <= nxt_col;
			phase_q   <= nxt_phase;
			count_q   <= nxt_count;
			seen_q    <= nxt_seen;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(CELLS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// screen RAM ports
	assign wr_addr_full = (ADDR_W + 1)'(cur_row_q * COLS) + (ADDR_W + 1)'(cur_col_q);
	assign rd_in_range  = (req.read_row < ROW_W'(ROWS)) && (req.read_col < COL_W'(COLS));
	assign rd_addr_full = (ADDR_W + 1)'(req.read_row * COLS) + (ADDR_W + 1)'(req.read_col);
	assign ram_we       = clr_busy_q || (accept && is_byte && nxt_written);
	assign ram_waddr    = clr_busy_q ? clr_addr_q : wr_addr_full[ADDR_W-1:0];
	assign ram_wdata    = clr_busy_q ? CH_SPACE : req.data_byte;

	acts_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept && !is_byte && rd_in_range),
		.raddr(rd_in_range ? rd_addr_full[ADDR_W-1:0] : '0),
		.rdata(ram_rdata)
	);

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s1_go) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1.is_read      <= !is_byte;
			s1_s1.in_range     <= rd_in_range;
			s1_s1.cursor_row   <= is_byte ? nxt_row : cur_row_q;
			s1_s1.cursor_col   <= is_byte ? nxt_col : cur_col_q;
			s1_s1.cell_written <= is_byte && nxt_written;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_s1) begin
			out_q.cell_char    <= (s1_s1.is_read && s1_s1.in_range) ? ram_rdata : 8'd0;
			out_q.cursor_row   <= s1_s1.cursor_row;
			out_q.cursor_col   <= s1_s1.cursor_col;
			out_q.cell_written <= s1_s1.cell_written;
		end
	end

	// checks
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !accept)
		else $error("item accepted during clearing pass");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q < ROW_W'(ROWS)) && (cur_col_q < COL_W'(COLS)))
		else $error("cursor left the screen");

	a_written_has_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.cell_written) |-> (rsp.cell_char == 8'd0))
		else $error("byte item carries a cell character");

	a_read_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_free) |=> s1_valid_s1)
		else $error("read stage item lost while output stalled");

endmodule

FILE: sv/acts_ram.sv
// acts_ram: generic simple dual-port RAM, one write and one registered read
// read data holds while the read enable is low
// no dependencies
module acts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
